>>> rtl/gbs_pkg.sv
// Package: shared constants, types and state codes for greedy box suppression.
package gbs_pkg;

    localparam int MAX_BOXES  = 64;
    localparam int COORD_BITS = 12;
    localparam int IDX_BITS   = $clog2(MAX_BOXES);
    localparam int CNT_BITS   = IDX_BITS + 1;
    localparam int SCORE_BITS = 16;
    localparam int OUT_IDX_BITS = 6;
    localparam int EDGE_BITS  = COORD_BITS + 1;
    localparam int AREA_BITS  = 2 * COORD_BITS;
    localparam int UNI_BITS   = AREA_BITS + 1;
    localparam int PROD_BITS  = SCORE_BITS + UNI_BITS;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

    localparam logic [CFG_IDX_BITS-1:0] CFG_SCORE_THR = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IOU_THR   = 2'd1;

    localparam logic [SCORE_BITS-1:0] SCORE_THR_RESET = 16'd16384;
    localparam logic [SCORE_BITS-1:0] IOU_THR_RESET   = 16'd29491;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] w;
        logic [COORD_BITS-1:0] h;
    } gbs_box_t;

    // One classified request from the front end to the back end
    typedef struct packed {
        gbs_box_t              box;
        logic [SCORE_BITS-1:0] score;
        logic                  pass;
        logic                  store;
        logic [IDX_BITS-1:0]   idx;
        logic                  final_box;
    } gbs_entry_t;

    typedef struct packed {
        logic                valid;
        logic                over;
        logic [IDX_BITS-1:0] idx;
    } gbs_iou_res_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_SUPP
    } gbs_state_t;

endpackage

>>> rtl/gbs_if.sv
// Interfaces: box request channel and result channel.
interface gbs_box_if;
    import gbs_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] box_x;
    logic [COORD_BITS-1:0] box_y;
    logic [COORD_BITS-1:0] box_width;
    logic [COORD_BITS-1:0] box_height;
    logic [SCORE_BITS-1:0] box_score;
    logic                  final_box;

    modport source (output valid, box_x, box_y, box_width, box_height, box_score,
                    final_box, input ready);
    modport sink   (input valid, box_x, box_y, box_width, box_height, box_score,
                    final_box, output ready);
endinterface

interface gbs_result_if;
    import gbs_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OUT_IDX_BITS-1:0] kept_index;
    logic                    last_kept;
    logic                    none_kept;

    modport source (output valid, kept_index, last_kept, none_kept, input ready);
    modport sink   (input valid, kept_index, last_kept, none_kept, output ready);
endinterface

>>> rtl/greedy_box_suppression_unit.sv
// Greedy box suppression unit: top level with configuration registers.
// Boxes are taken at one per cycle, while the four-entry queue is not full, and written
// to the box store by the back end, one per cycle while it is loading. The final box of
// a set starts processing: with N boxes loaded and K boxes kept, the set takes about
// (K+1) selection walks (one score-store read per box) plus K suppression walks (one
// read per box through the four-stage overlap pipeline). Boxes for the next set queue
// up meanwhile until the queue fills. No clearing pass is needed after reset. Kept
// indices come out in descending score order, the last flagged.
module greedy_box_suppression_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [gbs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [gbs_pkg::CFG_DATA_BITS-1:0] cfg_data,
    gbs_box_if.sink                           box,
    gbs_result_if.source                      result
);
    import gbs_pkg::*;

    logic [SCORE_BITS-1:0] score_thr_reg, score_thr_next;
    logic [SCORE_BITS-1:0] iou_thr_reg, iou_thr_next;
    logic                  q_push, q_full, q_pop, q_empty;
    gbs_entry_t            q_push_data, q_pop_data;

    always_comb
    begin
        score_thr_next = score_thr_reg;
        iou_thr_next   = iou_thr_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_SCORE_THR: score_thr_next = cfg_data;
                CFG_IOU_THR:   iou_thr_next   = cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_thr_reg <= SCORE_THR_RESET;
            iou_thr_reg   <= IOU_THR_RESET;
        end
        else
        begin
            score_thr_reg <= score_thr_next;
            iou_thr_reg   <= iou_thr_next;
        end
    end

    gbs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .box       (box),
        .score_thr (score_thr_reg),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full)
    );

    gbs_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    gbs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (q_empty),
        .pop_data (q_pop_data),
        .pop      (q_pop),
        .iou_thr  (iou_thr_reg),
        .result   (result)
    );

endmodule

>>> rtl/gbs_front.sv
// Front end: accept boxes, classify against the score threshold, assign slots.
module gbs_front (
    input  logic                           clk,
    input  logic                           rst_n,
    gbs_box_if.sink                        box,
    input  logic [gbs_pkg::SCORE_BITS-1:0] score_thr,
    output logic                           push,
    output gbs_pkg::gbs_entry_t            push_data,
    input  logic                           full
);
    import gbs_pkg::*;

    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic                store;

    assign box.ready = !full;
    assign push      = box.valid && !full;
    assign store     = (count_reg < CNT_BITS'(MAX_BOXES));

    assign push_data.box.x     = box.box_x;
    assign push_data.box.y     = box.box_y;
    assign push_data.box.w     = box.box_width;
    assign push_data.box.h     = box.box_height;
    assign push_data.score     = box.box_score;
    assign push_data.pass      = (box.box_score >= score_thr);
    assign push_data.store     = store;
    assign push_data.idx       = count_reg[IDX_BITS-1:0];
    assign push_data.final_box = box.final_box;

    always_comb
    begin
        count_next = count_reg;
        if (push)
        begin
            // the final box closes the set, whether stored or dropped
            if (box.final_box)
                count_next = '0;
            else if (store)
                count_next = count_reg + CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule

>>> rtl/gbs_fifo.sv
// Short request queue between front end and back end.
module gbs_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  gbs_pkg::gbs_entry_t push_data,
    output logic                full,
    input  logic                pop,
    output gbs_pkg::gbs_entry_t pop_data,
    output logic                empty
);
    import gbs_pkg::*;

    gbs_entry_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg;
    logic [FIFO_PTR_BITS-1:0] rd_ptr_reg;
    logic [FIFO_PTR_BITS:0]   cnt_reg;
    logic [FIFO_PTR_BITS-1:0] wr_ptr_next;
    logic [FIFO_PTR_BITS-1:0] rd_ptr_next;
    logic [FIFO_PTR_BITS:0]   cnt_next;
    logic                     do_push;
    logic                     do_pop;

    assign full     = (cnt_reg == (FIFO_PTR_BITS+1)'(FIFO_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + FIFO_PTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + FIFO_PTR_BITS'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + (FIFO_PTR_BITS+1)'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - (FIFO_PTR_BITS+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

>>> rtl/gbs_iou.sv
// Overlap test pipeline: inter * 65536 > threshold * union, four stages.
module gbs_iou (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [gbs_pkg::IDX_BITS-1:0]   in_idx,
    input  gbs_pkg::gbs_box_t              best_box,
    input  logic [gbs_pkg::AREA_BITS-1:0]  best_area,
    input  gbs_pkg::gbs_box_t              cand_box,
    input  logic [gbs_pkg::SCORE_BITS-1:0] iou_thr,
    output gbs_pkg::gbs_iou_res_t          res,
    output logic                           busy
);
    import gbs_pkg::*;

    logic [EDGE_BITS-1:0]  ax2, bx2, ay2, by2, lx, ty, rx, by;
    logic [EDGE_BITS-1:0]  iw, ih;
    logic [AREA_BITS-1:0]  area_b;
    logic [2*EDGE_BITS-1:0] inter_full;

    logic [3:0]            v_reg;
    logic [IDX_BITS-1:0]   idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    logic [EDGE_BITS-1:0]  iw1_reg, ih1_reg;
    logic [AREA_BITS-1:0]  areab1_reg, areab2_reg;
    logic [AREA_BITS-1:0]  inter2_reg, inter3_reg;
    logic [UNI_BITS-1:0]   uni3_reg;
    logic [PROD_BITS-1:0]  rhs4_reg;
    logic [PROD_BITS-1:0]  lhs4_reg;

    always_comb
    begin
        ax2 = {1'b0, best_box.x} + {1'b0, best_box.w};
        bx2 = {1'b0, cand_box.x} + {1'b0, cand_box.w};
        ay2 = {1'b0, best_box.y} + {1'b0, best_box.h};
        by2 = {1'b0, cand_box.y} + {1'b0, cand_box.h};
        lx  = (best_box.x > cand_box.x) ? {1'b0, best_box.x} : {1'b0, cand_box.x};
        ty  = (best_box.y > cand_box.y) ? {1'b0, best_box.y} : {1'b0, cand_box.y};
        rx  = (ax2 < bx2) ? ax2 : bx2;
        by  = (ay2 < by2) ? ay2 : by2;
        iw  = (rx > lx) ? rx - lx : '0;
        ih  = (by > ty) ? by - ty : '0;
        area_b = cand_box.w * cand_box.h;
    end

    // overlap never exceeds the narrower box, so the product fits an area
    assign inter_full = iw1_reg * ih1_reg;

    assign busy      = |v_reg;
    assign res.valid = v_reg[3];
    assign res.idx   = idx4_reg;
    assign res.over  = (lhs4_reg > rhs4_reg);

    always_ff @(posedge clk)
    begin
        idx1_reg   <= in_idx;
        iw1_reg    <= iw;
        ih1_reg    <= ih;
        areab1_reg <= area_b;
        idx2_reg   <= idx1_reg;
        inter2_reg <= inter_full[AREA_BITS-1:0];
        areab2_reg <= areab1_reg;
        idx3_reg   <= idx2_reg;
        inter3_reg <= inter2_reg;
        uni3_reg   <= {1'b0, best_area} + {1'b0, areab2_reg} - {1'b0, inter2_reg};
        idx4_reg   <= idx3_reg;
        rhs4_reg   <= iou_thr * uni3_reg;
        lhs4_reg   <= PROD_BITS'({inter3_reg, 16'h0000});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[2:0], in_valid};
    end

endmodule

>>> rtl/gbs_back.sv
// Back end: box memories, greedy selection and suppression passes, result register.
module gbs_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           empty,
    input  gbs_pkg::gbs_entry_t            pop_data,
    output logic                           pop,
    input  logic [gbs_pkg::SCORE_BITS-1:0] iou_thr,
    gbs_result_if.source                   result
);
    import gbs_pkg::*;

    gbs_box_t              box_mem   [MAX_BOXES];
    logic [SCORE_BITS-1:0] score_mem [MAX_BOXES];
    gbs_box_t              rd_box_reg;
    logic [SCORE_BITS-1:0] rd_score_reg;
    logic [IDX_BITS-1:0]   rd_addr;
    logic                  mem_we;

    gbs_state_t            state_reg, state_next;
    logic [CNT_BITS-1:0]   ptr_reg, ptr_next;
    logic [CNT_BITS-1:0]   nbox_reg, nbox_next;
    logic                  pv_reg, pv_next;
    logic [IDX_BITS-1:0]   pi_reg, pi_next;
    logic [MAX_BOXES-1:0]  alive_reg, alive_next;
    logic                  best_found_reg, best_found_next;
    logic [IDX_BITS-1:0]   best_idx_reg, best_idx_next;
    logic [SCORE_BITS-1:0] best_score_reg, best_score_next;
    gbs_box_t              best_box_reg, best_box_next;
    logic [AREA_BITS-1:0]  best_area_reg, best_area_next;
    logic                  hold_v_reg, hold_v_next;
    logic [IDX_BITS-1:0]   hold_idx_reg, hold_idx_next;
    logic                  ov_reg, ov_next;
    logic [OUT_IDX_BITS-1:0] o_idx_reg, o_idx_next;
    logic                  o_last_reg, o_last_next;
    logic                  o_none_reg, o_none_next;

    logic                  out_free;
    logic                  walk_done;
    gbs_iou_res_t          iou_res;
    logic                  iou_busy;
    logic                  iou_in_valid;

    assign rd_addr      = ptr_reg[IDX_BITS-1:0];
    assign out_free     = !ov_reg || result.ready;
    assign walk_done    = (ptr_reg == nbox_reg) && !pv_reg;
    assign iou_in_valid = pv_reg && (state_reg == ST_SUPP);

    assign result.valid      = ov_reg;
    assign result.kept_index = o_idx_reg;
    assign result.last_kept  = o_last_reg;
    assign result.none_kept  = o_none_reg;

    gbs_iou u_iou (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (iou_in_valid),
        .in_idx    (pi_reg),
        .best_box  (best_box_reg),
        .best_area (best_area_reg),
        .cand_box  (rd_box_reg),
        .iou_thr   (iou_thr),
        .res       (iou_res),
        .busy      (iou_busy)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            box_mem[pop_data.idx]   <= pop_data.box;
            score_mem[pop_data.idx] <= pop_data.score;
        end
        rd_box_reg   <= box_mem[rd_addr];
        rd_score_reg <= score_mem[rd_addr];
    end

    always_comb
    begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        nbox_next       = nbox_reg;
        pv_next         = 1'b0;
        pi_next         = ptr_reg[IDX_BITS-1:0];
        alive_next      = alive_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_score_next = best_score_reg;
        best_box_next   = best_box_reg;
        best_area_next  = best_area_reg;
        hold_v_next     = hold_v_reg;
        hold_idx_next   = hold_idx_reg;
        ov_next         = ov_reg && !result.ready;
        o_idx_next      = o_idx_reg;
        o_last_next     = o_last_reg;
        o_none_next     = o_none_reg;
        pop             = 1'b0;
        mem_we          = 1'b0;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (!empty)
                begin
                    pop = 1'b1;
                    if (pop_data.store)
                    begin
                        mem_we                   = 1'b1;
                        alive_next[pop_data.idx] = pop_data.pass;
                        nbox_next                = {1'b0, pop_data.idx} + CNT_BITS'(1);
                    end
                    if (pop_data.final_box)
                    begin
                        state_next      = ST_SCAN;
                        ptr_next        = '0;
                        best_found_next = 1'b0;
                    end
                end
            end

            ST_SCAN:
            begin
                if (ptr_reg < nbox_reg)
                begin
                    pv_next  = 1'b1;
                    ptr_next = ptr_reg + CNT_BITS'(1);
                end
                // strict compare in arrival order keeps the lower index on ties
                if (pv_reg && alive_reg[pi_reg]
                    && (!best_found_reg || rd_score_reg > best_score_reg))
                begin
                    best_found_next = 1'b1;
                    best_idx_next   = pi_reg;
                    best_score_next = rd_score_reg;
                    best_box_next   = rd_box_reg;
                    best_area_next  = rd_box_reg.w * rd_box_reg.h;
                end
                if (walk_done)
                begin
                    if (best_found_reg)
                    begin
                        if (!hold_v_reg || out_free)
                        begin
                            if (hold_v_reg)
                            begin
                                ov_next     = 1'b1;
                                o_idx_next  = OUT_IDX_BITS'(hold_idx_reg);
                                o_last_next = 1'b0;
                                o_none_next = 1'b0;
                            end
                            hold_v_next               = 1'b1;
                            hold_idx_next             = best_idx_reg;
                            alive_next[best_idx_reg]  = 1'b0;
                            state_next                = ST_SUPP;
                            ptr_next                  = '0;
                        end
                    end
                    else if (out_free)
                    begin
                        ov_next     = 1'b1;
                        o_idx_next  = hold_v_reg ? OUT_IDX_BITS'(hold_idx_reg) : '0;
                        o_last_next = 1'b1;
                        o_none_next = !hold_v_reg;
                        hold_v_next = 1'b0;
                        nbox_next   = '0;
                        state_next  = ST_LOAD;
                    end
                end
            end

            ST_SUPP:
            begin
                if (ptr_reg < nbox_reg)
                begin
                    pv_next  = 1'b1;
                    ptr_next = ptr_reg + CNT_BITS'(1);
                end
                if (iou_res.valid && iou_res.over)
                    alive_next[iou_res.idx] = 1'b0;
                // drain the overlap pipeline before the next selection walk
                if (walk_done && !iou_busy)
                begin
                    state_next      = ST_SCAN;
                    ptr_next        = '0;
                    best_found_next = 1'b0;
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        pi_reg         <= pi_next;
        best_idx_reg   <= best_idx_next;
        best_score_reg <= best_score_next;
        best_box_reg   <= best_box_next;
        best_area_reg  <= best_area_next;
        hold_idx_reg   <= hold_idx_next;
        o_idx_reg      <= o_idx_next;
        o_last_reg     <= o_last_next;
        o_none_reg     <= o_none_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            ptr_reg        <= '0;
            nbox_reg       <= '0;
            pv_reg         <= 1'b0;
            alive_reg      <= '0;
            best_found_reg <= 1'b0;
            hold_v_reg     <= 1'b0;
            ov_reg         <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ptr_reg        <= ptr_next;
            nbox_reg       <= nbox_next;
            pv_reg         <= pv_next;
            alive_reg      <= alive_next;
            best_found_reg <= best_found_next;
            hold_v_reg     <= hold_v_next;
            ov_reg         <= ov_next;
        end
    end

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> (ptr_reg <= nbox_reg))
        else $error("walk pointer beyond loaded boxes");

    a_set_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && state_next == ST_LOAD) |=> (alive_reg == '0))
        else $error("live boxes left at end of set");

    a_kept_dead: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUPP) |-> !alive_reg[best_idx_reg])
        else $error("kept box still marked live during suppression");

    a_nbox_max: assert property (@(posedge clk) disable iff (!rst_n)
        nbox_reg <= CNT_BITS'(MAX_BOXES))
        else $error("box count beyond store depth");

endmodule
